>>> hw/rtl/loop_clip_record_play_crossfade_unit_macros.svh
// Assertion macros shared by the looper clip RTL.
`ifndef LOOP_CLIP_RECORD_PLAY_CROSSFADE_UNIT_MACROS_SVH
`define LOOP_CLIP_RECORD_PLAY_CROSSFADE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LCRPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LCRPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LCRPC_ASSERT_IMP(lbl, ante, cons, msg)
`define LCRPC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/lcrpc_pkg.sv
// Types and constants of the looper clip.
package lcrpc_pkg;

  localparam int POS_W    = 11;
  localparam int LIM_W    = 12;
  localparam int CAP_W    = 11;
  localparam int FLAG_W   = 6;
  localparam int SAMPLE_W = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam int F_REC_IN    = 0;
  localparam int F_REC_MAIN  = 1;
  localparam int F_REC_END   = 2;
  localparam int F_RECORDED  = 3;
  localparam int F_PLAY_MAIN = 4;
  localparam int F_PLAY_END  = 5;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_STOP   = 3'd1,
    OP_PLAY   = 3'd2,
    OP_RECORD = 3'd3,
    OP_ABORT  = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]                 op;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [SAMPLE_W-1:0] mix_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic [FLAG_W-1:0]          clip_flags;
    logic                       overflow;
    logic                       block_end;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic              main_en;
    logic              fade_en;
    logic              fwd_main;
    logic              fwd_fade;
    logic [FLAG_W-1:0] flags;
    logic              overflow;
    logic              block_end;
  } ctl_info_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix;
    logic                       neg_main;
    logic                       neg_fade;
    logic [FLAG_W-1:0]          flags;
    logic                       overflow;
    logic                       block_end;
  } pipe_tag_t;

endpackage

>>> hw/rtl/lcrpc_ctl.sv
// Clip control: flags, block counters, addresses and gains for each item.
`include "loop_clip_record_play_crossfade_unit_macros.svh"
module lcrpc_ctl
  import lcrpc_pkg::*;
#(
  parameter int CROSSFADE     = 4,
  parameter int BLOCK_SAMPLES = 128,
  parameter int CHANNELS      = 2,
  parameter int MAX_BLOCKS    = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  in_item_t               item,
  input  logic                   cfg_valid,
  input  logic [CAP_W-1:0]       cfg_data,
  output logic [$clog2(MAX_BLOCKS*CHANNELS*BLOCK_SAMPLES)-1:0] wr_addr,
  output logic [$clog2(MAX_BLOCKS*CHANNELS*BLOCK_SAMPLES)-1:0] rd_main_addr,
  output logic [$clog2(MAX_BLOCKS*CHANNELS*BLOCK_SAMPLES)-1:0] rd_fade_addr,
  output logic [$clog2(CROSSFADE*BLOCK_SAMPLES+1)-1:0]         gain_main,
  output logic [$clog2(CROSSFADE*BLOCK_SAMPLES+1)-1:0]         gain_fade,
  output ctl_info_t              info
);

  localparam int D         = CROSSFADE * BLOCK_SAMPLES;
  localparam int GW        = $clog2(D + 1);
  localparam int MEM_WORDS = MAX_BLOCKS * CHANNELS * BLOCK_SAMPLES;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam int SIW       = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam int CIW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FOW       = $clog2(CROSSFADE + 1);
  localparam int MBW       = $clog2(MAX_BLOCKS + 1);
  localparam int BW        = (LIM_W > MBW) ? LIM_W : MBW;
  localparam int FAW       = BW + $clog2(CHANNELS * BLOCK_SAMPLES) + 1;
  localparam int CH_RECIP  = ((1 << 16) + CHANNELS - 1) / CHANNELS;

  logic [CAP_W-1:0]  cap_r;
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic [POS_W-1:0]  rpos_r, rpos_nxt;
  logic [POS_W-1:0]  ppos_r, ppos_nxt;
  logic [POS_W-1:0]  fstart_r, fstart_nxt;
  logic [FOW-1:0]    foff_r, foff_nxt;
  logic [POS_W-1:0]  llen_r, llen_nxt;
  logic [LIM_W-1:0]  lim_r, lim_nxt;
  logic [SIW-1:0]    sidx_r, sidx_nxt;
  logic [CIW-1:0]    cidx_r, cidx_nxt;

  logic             rec_any, dropped, s_last, c_last, bend;
  logic [FAW-1:0]   wr_full, rdm_full, rdf_full;
  logic [LIM_W-1:0] fblk;
  logic [CAP_W+16:0] cap_prod;
  logic [16:0]      blk17;

  function automatic logic [FAW-1:0] addr_of(input logic [LIM_W-1:0] blk,
                                             input logic [CIW-1:0] ch,
                                             input logic [SIW-1:0] si);
    addr_of = (FAW'(blk) * FAW'(CHANNELS) + FAW'(ch)) * FAW'(BLOCK_SAMPLES) + FAW'(si);
  endfunction

  assign rec_any  = |flags_r[F_REC_END:F_REC_IN];
  assign dropped  = (flags_r[F_REC_IN] | flags_r[F_REC_MAIN]) && ({1'b0, rpos_r} >= lim_r);
  assign fblk     = LIM_W'(fstart_r) + LIM_W'(foff_r);
  assign wr_full  = addr_of(LIM_W'(rpos_r), cidx_r, sidx_r);
  assign rdm_full = addr_of(LIM_W'(ppos_r), cidx_r, sidx_r);
  assign rdf_full = addr_of(fblk, cidx_r, sidx_r);
  assign wr_addr      = wr_full[AW-1:0];
  assign rd_main_addr = rdm_full[AW-1:0];
  assign rd_fade_addr = rdf_full[AW-1:0];

  assign gain_main = (ppos_r < POS_W'(CROSSFADE))
                   ? GW'(ppos_r) * GW'(BLOCK_SAMPLES) + GW'(sidx_r) : GW'(D);
  assign gain_fade = (GW'(CROSSFADE) - GW'(foff_r)) * GW'(BLOCK_SAMPLES) - GW'(sidx_r);

  assign s_last = (sidx_r == SIW'(BLOCK_SAMPLES - 1));
  assign c_last = (cidx_r == CIW'(CHANNELS - 1));
  assign bend   = s_last && c_last;

  assign cap_prod = (CAP_W+17)'(cap_r) * (CAP_W+17)'(CH_RECIP);

  always_comb begin
    info.wr_en     = rec_any && !dropped && (wr_full < FAW'(MEM_WORDS));
    info.main_en   = flags_r[F_PLAY_MAIN] && (rdm_full < FAW'(MEM_WORDS));
    info.fade_en   = flags_r[F_PLAY_END] && (rdf_full < FAW'(MEM_WORDS));
    info.fwd_main  = info.wr_en && info.main_en && (wr_addr == rd_main_addr);
    info.fwd_fade  = info.wr_en && info.fade_en && (wr_addr == rd_fade_addr);
    info.flags     = flags_nxt;
    info.overflow  = rec_any && dropped;
    info.block_end = bend;
  end

  always_comb begin
    flags_nxt  = flags_r;
    rpos_nxt   = rpos_r;
    ppos_nxt   = ppos_r;
    fstart_nxt = fstart_r;
    foff_nxt   = foff_r;
    llen_nxt   = llen_r;
    lim_nxt    = lim_r;
    sidx_nxt   = sidx_r;
    cidx_nxt   = cidx_r;
    blk17      = 17'(cap_prod[CAP_W+15:16]);
    if (blk17 > 17'(MAX_BLOCKS)) begin
      blk17 = 17'(MAX_BLOCKS);
    end
    if (accept) begin
      unique case (item.op)
        OP_SAMPLE: begin
          sidx_nxt = s_last ? '0 : sidx_r + 1'b1;
          cidx_nxt = s_last ? (c_last ? '0 : cidx_r + 1'b1) : cidx_r;
          if (bend) begin
            if (rec_any && !dropped) begin
              rpos_nxt = rpos_r + 1'b1;
              if (flags_nxt[F_REC_IN] && rpos_nxt >= POS_W'(CROSSFADE)) begin
                flags_nxt[F_REC_IN]   = 1'b0;
                flags_nxt[F_REC_MAIN] = 1'b1;
              end else if (flags_nxt[F_REC_END] &&
                           {1'b0, rpos_nxt} == LIM_W'(llen_r) + LIM_W'(CROSSFADE)) begin
                flags_nxt[F_REC_END]  = 1'b0;
                flags_nxt[F_RECORDED] = 1'b1;
              end
            end
            if (flags_nxt[F_PLAY_END]) begin
              foff_nxt = foff_r + 1'b1;
              if (foff_nxt == FOW'(CROSSFADE)) begin
                flags_nxt[F_PLAY_END] = 1'b0;
                fstart_nxt = '0;
                foff_nxt   = '0;
              end
            end
            if (flags_nxt[F_PLAY_MAIN]) begin
              ppos_nxt = ppos_r + 1'b1;
              if (ppos_nxt == llen_r) begin
                flags_nxt[F_PLAY_END] = 1'b1;
                fstart_nxt = ppos_nxt;
                foff_nxt   = '0;
                ppos_nxt   = '0;
              end
            end
          end
        end
        OP_STOP: begin
          if (flags_r[F_REC_MAIN]) begin
            llen_nxt = rpos_r;
            lim_nxt  = LIM_W'(rpos_r) + LIM_W'(CROSSFADE);
            flags_nxt[F_REC_MAIN] = 1'b0;
            flags_nxt[F_REC_END]  = 1'b1;
          end else if (flags_r[F_PLAY_MAIN]) begin
            if (ppos_r != '0) begin
              fstart_nxt = ppos_r;
            end
            flags_nxt[F_PLAY_MAIN] = 1'b0;
            flags_nxt[F_PLAY_END]  = 1'b1;
            foff_nxt = '0;
            ppos_nxt = '0;
          end
        end
        OP_PLAY: begin
          if (flags_r[F_REC_MAIN]) begin
            llen_nxt = rpos_r;
            lim_nxt  = LIM_W'(rpos_r) + LIM_W'(CROSSFADE);
            flags_nxt[F_REC_MAIN] = 1'b0;
            flags_nxt[F_REC_END]  = 1'b1;
          end
          ppos_nxt   = '0;
          fstart_nxt = '0;
          foff_nxt   = '0;
          flags_nxt[F_PLAY_MAIN] = 1'b1;
        end
        OP_RECORD: begin
          ppos_nxt   = '0;
          rpos_nxt   = '0;
          fstart_nxt = '0;
          foff_nxt   = '0;
          llen_nxt   = '0;
          lim_nxt    = (blk17 > 17'(CROSSFADE)) ? LIM_W'(blk17 - 17'(CROSSFADE)) : '0;
          flags_nxt[F_REC_IN] = 1'b1;
        end
        OP_ABORT: begin
          ppos_nxt   = '0;
          fstart_nxt = '0;
          foff_nxt   = '0;
          if (rec_any) begin
            flags_nxt = '0;
            rpos_nxt  = '0;
            llen_nxt  = '0;
            lim_nxt   = '0;
          end else begin
            flags_nxt[F_RECORDED] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      flags_r  <= '0;
      rpos_r   <= '0;
      ppos_r   <= '0;
      fstart_r <= '0;
      foff_r   <= '0;
      llen_r   <= '0;
      lim_r    <= '0;
      sidx_r   <= '0;
      cidx_r   <= '0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      flags_r  <= flags_nxt;
      rpos_r   <= rpos_nxt;
      ppos_r   <= ppos_nxt;
      fstart_r <= fstart_nxt;
      foff_r   <= foff_nxt;
      llen_r   <= llen_nxt;
      lim_r    <= lim_nxt;
      sidx_r   <= sidx_nxt;
      cidx_r   <= cidx_nxt;
    end
  end

  `LCRPC_ASSERT_NXT(a_abort_clears, accept && item.op == OP_ABORT && rec_any, flags_r == '0 && rpos_r == '0, "abort while recording did not clear the clip")
  `LCRPC_ASSERT_IMP(a_fade_off_range, flags_r[F_PLAY_END], foff_r < FOW'(CROSSFADE), "fade offset out of range")
  `LCRPC_ASSERT_IMP(a_fwd_needs_write, info.fwd_main || info.fwd_fade, rec_any && !dropped, "forward without a recorded sample")

endmodule

>>> hw/rtl/lcrpc_mix.sv
// Clip memory and the fade/mix pipeline from memory read to result register.
`include "loop_clip_record_play_crossfade_unit_macros.svh"
module lcrpc_mix
  import lcrpc_pkg::*;
#(
  parameter int CROSSFADE     = 4,
  parameter int BLOCK_SAMPLES = 128,
  parameter int CHANNELS      = 2,
  parameter int MAX_BLOCKS    = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      smp_load,
  input  in_item_t  item,
  input  logic [$clog2(MAX_BLOCKS*CHANNELS*BLOCK_SAMPLES)-1:0] wr_addr,
  input  logic [$clog2(MAX_BLOCKS*CHANNELS*BLOCK_SAMPLES)-1:0] rd_main_addr,
  input  logic [$clog2(MAX_BLOCKS*CHANNELS*BLOCK_SAMPLES)-1:0] rd_fade_addr,
  input  logic [$clog2(CROSSFADE*BLOCK_SAMPLES+1)-1:0]         gain_main,
  input  logic [$clog2(CROSSFADE*BLOCK_SAMPLES+1)-1:0]         gain_fade,
  input  ctl_info_t info,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int D         = CROSSFADE * BLOCK_SAMPLES;
  localparam int GW        = $clog2(D + 1);
  localparam int PW        = SAMPLE_W + GW;
  localparam int MEM_WORDS = MAX_BLOCKS * CHANNELS * BLOCK_SAMPLES;
  localparam longint RECIP = (64'd1 << 31) / D;

  logic [SAMPLE_W-1:0] mem [MEM_WORDS];

  logic ld1, go2, go3, go4, go5;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  logic [SAMPLE_W-1:0] rdm_r, rdf_r, live1_r;
  logic signed [SAMPLE_W-1:0] mix1_r;
  logic [GW-1:0]       gm1_r, gf1_r;
  ctl_info_t           info1_r;

  logic [SAMPLE_W-1:0] sm, sf, magm, magf;
  logic [PW-1:0]       p2m_r, p2f_r, p3m_r, p3f_r, p4m_r, p4f_r, qd4m_r, qd4f_r;
  logic [PW+31:0]      prodm, prodf;
  logic [SAMPLE_W-1:0] qe3m_r, qe3f_r, qe4m_r, qe4f_r, qm, qf;
  pipe_tag_t           tag1, tag2_r, tag3_r, tag4_r;
  out_item_t           out_nxt;

  assign go5 = !out_valid_r || !out_stall;
  assign go4 = !v4_r || go5;
  assign go3 = !v3_r || go4;
  assign go2 = !v2_r || go3;
  assign ld1 = !v1_r || go2;
  assign in_stall  = !ld1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (smp_load) begin
      if (info.wr_en) begin
        mem[wr_addr] <= item.in_sample;
      end
      rdm_r <= mem[rd_main_addr];
      rdf_r <= mem[rd_fade_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      live1_r <= item.in_sample;
      mix1_r  <= item.mix_in;
      gm1_r   <= gain_main;
      gf1_r   <= gain_fade;
      info1_r <= info;
    end
  end

  always_comb begin
    sm   = info1_r.fwd_main ? live1_r : rdm_r;
    sf   = info1_r.fwd_fade ? live1_r : rdf_r;
    magm = sm[SAMPLE_W-1] ? SAMPLE_W'(-sm) : sm;
    magf = sf[SAMPLE_W-1] ? SAMPLE_W'(-sf) : sf;
    tag1.mix       = mix1_r;
    tag1.neg_main  = sm[SAMPLE_W-1];
    tag1.neg_fade  = sf[SAMPLE_W-1];
    tag1.flags     = info1_r.flags;
    tag1.overflow  = info1_r.overflow;
    tag1.block_end = info1_r.block_end;
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      p2m_r  <= info1_r.main_en ? PW'(magm) * PW'(gm1_r) : '0;
      p2f_r  <= info1_r.fade_en ? PW'(magf) * PW'(gf1_r) : '0;
      tag2_r <= tag1;
    end
  end

  assign prodm = (PW+32)'(p2m_r) * (PW+32)'(RECIP);
  assign prodf = (PW+32)'(p2f_r) * (PW+32)'(RECIP);

  always_ff @(posedge clk) begin
    if (go3) begin
      qe3m_r <= prodm[31 +: SAMPLE_W];
      qe3f_r <= prodf[31 +: SAMPLE_W];
      p3m_r  <= p2m_r;
      p3f_r  <= p2f_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go4) begin
      qd4m_r <= PW'(qe3m_r) * PW'(D);
      qd4f_r <= PW'(qe3f_r) * PW'(D);
      qe4m_r <= qe3m_r;
      qe4f_r <= qe3f_r;
      p4m_r  <= p3m_r;
      p4f_r  <= p3f_r;
      tag4_r <= tag3_r;
    end
  end

  // quotient estimate is exact or one low
  always_comb begin
    qm = ((p4m_r - qd4m_r) >= PW'(D)) ? qe4m_r + 1'b1 : qe4m_r;
    qf = ((p4f_r - qd4f_r) >= PW'(D)) ? qe4f_r + 1'b1 : qe4f_r;
    out_nxt.out_sample = tag4_r.mix
                       + (tag4_r.neg_main ? SAMPLE_W'(-qm) : qm)
                       + (tag4_r.neg_fade ? SAMPLE_W'(-qf) : qf);
    out_nxt.clip_flags = tag4_r.flags;
    out_nxt.overflow   = tag4_r.overflow;
    out_nxt.block_end  = tag4_r.block_end;
  end

  always_ff @(posedge clk) begin
    if (go5) begin
      out_data <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= smp_load;
      end
      if (go2) begin
        v2_r <= v1_r;
      end
      if (go3) begin
        v3_r <= v2_r;
      end
      if (go4) begin
        v4_r <= v3_r;
      end
      if (go5) begin
        out_valid_r <= v4_r;
      end
    end
  end

  `LCRPC_ASSERT_IMP(a_stall_only_full, in_stall, v1_r && v2_r && v3_r && v4_r && out_valid_r && out_stall, "input stalled with room in the pipeline")

endmodule

>>> hw/rtl/loop_clip_record_play_crossfade_unit.sv
// Top level of the looper clip: record, play and crossfade into a mix bus.
//
// Input channel (in_valid/in_stall, in_data): one item per handshake, either a
// sample (op sample) or a command (stop, play, record, abort). Samples come in
// block order, channel-major. Commands change clip state at once, give no result.
// Result channel (out_valid/out_stall, out_data): one item per sample, carrying
// mix_in plus faded playback, the clip flags, overflow and block end.
// Config channel (cfg_valid/cfg_ready, cfg_data): free capacity in blocks;
// cfg_ready is always high. Write only while the block is idle.
// Throughput is one item per cycle when out_stall is low; the clip memory
// does one write and two reads per sample in the accept cycle, then a
// four-stage mix pipeline (gain multiply, reciprocal multiply, quotient
// check) feeds the result register, which adds the mix. When out_stall is
// high the pipeline fills and in_stall rises only once all five registers
// hold results. Reset (rst_n low, synchronous) clears flags, counters and
// pipeline valids and sets capacity to 1024; clip memory is undefined until
// recorded.
module loop_clip_record_play_crossfade_unit
  import lcrpc_pkg::*;
#(
  parameter int CROSSFADE     = 4,
  parameter int BLOCK_SAMPLES = 128,
  parameter int CHANNELS      = 2,
  parameter int MAX_BLOCKS    = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_BLOCKS * CHANNELS * BLOCK_SAMPLES);
  localparam int GW = $clog2(CROSSFADE * BLOCK_SAMPLES + 1);

  logic          accept, smp_load;
  logic [AW-1:0] wr_addr, rd_main_addr, rd_fade_addr;
  logic [GW-1:0] gain_main, gain_fade;
  ctl_info_t     info;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign smp_load  = accept && (in_data.op == OP_SAMPLE);

  lcrpc_ctl #(
    .CROSSFADE    (CROSSFADE),
    .BLOCK_SAMPLES(BLOCK_SAMPLES),
    .CHANNELS     (CHANNELS),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_ctl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_data),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .wr_addr     (wr_addr),
    .rd_main_addr(rd_main_addr),
    .rd_fade_addr(rd_fade_addr),
    .gain_main   (gain_main),
    .gain_fade   (gain_fade),
    .info        (info)
  );

  lcrpc_mix #(
    .CROSSFADE    (CROSSFADE),
    .BLOCK_SAMPLES(BLOCK_SAMPLES),
    .CHANNELS     (CHANNELS),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .smp_load    (smp_load),
    .item        (in_data),
    .wr_addr     (wr_addr),
    .rd_main_addr(rd_main_addr),
    .rd_fade_addr(rd_fade_addr),
    .gain_main   (gain_main),
    .gain_fade   (gain_fade),
    .info        (info),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

>>> test/tb.sv
// Testbench for the looper clip: directed, record-and-play and random items, checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import lcrpc_pkg::*;

  localparam int XF = 4;
  localparam int BS = 128;
  localparam int NCH = 2;
  localparam int MB = 1024;
  localparam int MEM_WORDS = MB * NCH * BS;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  loop_clip_record_play_crossfade_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // clip model state
  logic [15:0] clip_mem [MEM_WORDS];
  bit written [MEM_WORDS];
  logic [5:0] fl;
  int unsigned cap_blocks = 1024;
  int unsigned rec_pos, play_pos, fade_base, fade_off, loop_len, samp_idx, chan_idx, rec_lim;

  out_item_t mix_results[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_ovf = 0;
  int n_fade = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;

  function automatic longint clip_addr(int unsigned blk, int unsigned ch, int unsigned i);
    return (longint'(blk) * NCH + ch) * BS + i;
  endfunction

  function automatic int clip_read(longint a);
    if (a >= MEM_WORDS) return 0;
    return int'($signed(clip_mem[a]));
  endfunction

  function automatic int faded(int s, longint g);
    longint p;
    p = longint'(s) * g;
    return int'(p / (XF * BS));
  endfunction

  function automatic bit rec_any();
    return fl[F_REC_IN] | fl[F_REC_MAIN] | fl[F_REC_END];
  endfunction

  function automatic bit rec_blocked();
    return (fl[F_REC_IN] | fl[F_REC_MAIN]) && rec_pos >= rec_lim;
  endfunction

  function automatic void clear_clip();
    fl = '0;
    rec_pos = 0; play_pos = 0; fade_base = 0; fade_off = 0; loop_len = 0; rec_lim = 0;
  endfunction

  function automatic void finish_take();
    loop_len = rec_pos;
    rec_lim = rec_pos + XF;
    fl[F_REC_MAIN] = 1'b0;
    fl[F_REC_END] = 1'b1;
  endfunction

  function automatic void advance_block();
    if (rec_any() && !rec_blocked()) begin
      rec_pos = (rec_pos + 1) & 11'h7FF;
      if (fl[F_REC_IN] && rec_pos >= XF) begin
        fl[F_REC_IN] = 1'b0;
        fl[F_REC_MAIN] = 1'b1;
      end else if (fl[F_REC_END] && rec_pos == loop_len + XF) begin
        fl[F_REC_END] = 1'b0;
        fl[F_RECORDED] = 1'b1;
      end
    end
    if (fl[F_PLAY_END]) begin
      fade_off++;
      if (fade_off == XF) begin
        fl[F_PLAY_END] = 1'b0;
        fade_base = 0;
        fade_off = 0;
      end
    end
    if (fl[F_PLAY_MAIN]) begin
      play_pos = (play_pos + 1) & 11'h7FF;
      if (play_pos == loop_len) begin
        fl[F_PLAY_END] = 1'b1;
        fade_base = play_pos;
        fade_off = 0;
        play_pos = 0;
      end
    end
  endfunction

  // true when the next sample reads only written clip memory
  function automatic bit reads_known();
    longint wa, ra;
    bit wr;
    bit ok;
    wr = rec_any() && !rec_blocked();
    wa = clip_addr(rec_pos, chan_idx, samp_idx);
    ok = 1'b1;
    if (fl[F_PLAY_MAIN]) begin
      ra = clip_addr(play_pos, chan_idx, samp_idx);
      if (ra < MEM_WORDS && !written[ra] && !(wr && ra == wa)) ok = 1'b0;
    end
    if (fl[F_PLAY_END]) begin
      ra = clip_addr(fade_base + fade_off, chan_idx, samp_idx);
      if (ra < MEM_WORDS && !written[ra] && !(wr && ra == wa)) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void predict_mix(in_item_t it, output bit has, output out_item_t r);
    int unsigned blocks, ch, i;
    int acc, s;
    longint a;
    bit ovf, bend;
    has = 1'b0;
    r = '0;
    case (it.op)
      OP_STOP: begin
        if (fl[F_REC_MAIN]) finish_take();
        else if (fl[F_PLAY_MAIN]) begin
          if (play_pos != 0) fade_base = play_pos;
          fl[F_PLAY_MAIN] = 1'b0;
          fl[F_PLAY_END] = 1'b1;
          fade_off = 0;
          play_pos = 0;
        end
      end
      OP_PLAY: begin
        if (fl[F_REC_MAIN]) finish_take();
        play_pos = 0; fade_base = 0; fade_off = 0;
        fl[F_PLAY_MAIN] = 1'b1;
      end
      OP_RECORD: begin
        blocks = cap_blocks / NCH;
        if (blocks > MB) blocks = MB;
        play_pos = 0; rec_pos = 0; fade_base = 0; fade_off = 0; loop_len = 0;
        rec_lim = blocks > XF ? blocks - XF : 0;
        fl[F_REC_IN] = 1'b1;
      end
      OP_ABORT: begin
        if (rec_any()) clear_clip();
        else begin
          play_pos = 0; fade_base = 0; fade_off = 0;
          fl[F_RECORDED] = 1'b1;
        end
      end
      OP_SAMPLE: begin
        has = 1'b1;
        ch = chan_idx;
        i = samp_idx;
        acc = int'(it.mix_in);
        ovf = 1'b0;
        bend = 1'b0;
        if (rec_any()) begin
          if (rec_blocked()) ovf = 1'b1;
          else begin
            a = clip_addr(rec_pos, ch, i);
            if (a < MEM_WORDS) begin
              clip_mem[a] = it.in_sample;
              written[a] = 1'b1;
            end
          end
        end
        if (fl[F_PLAY_MAIN]) begin
          s = clip_read(clip_addr(play_pos, ch, i));
          if (play_pos < XF) acc += faded(s, longint'(play_pos) * BS + i);
          else acc += s;
        end
        if (fl[F_PLAY_END]) begin
          s = clip_read(clip_addr(fade_base + fade_off, ch, i));
          acc += faded(s, (longint'(XF) - fade_off) * BS - i);
          n_fade++;
        end
        i++;
        if (i >= BS) begin
          i = 0;
          ch++;
          if (ch >= NCH) begin
            ch = 0;
            bend = 1'b1;
          end
        end
        samp_idx = i;
        chan_idx = ch;
        if (bend) advance_block();
        r.out_sample = acc[15:0];
        r.clip_flags = fl;
        r.overflow = ovf;
        r.block_end = bend;
        n_ovf += ovf;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    bit has;
    out_item_t r;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_mix(it, has, r);
    if (has) mix_results.push_back(r);
    n_items++;
  endtask

  task automatic send_cmd(logic [2:0] op);
    in_item_t it;
    it.op = op;
    it.in_sample = 16'($urandom());
    it.mix_in = 16'($urandom());
    send_item(it);
  endtask

  // clears the clip first when the sample would play back unrecorded memory
  task automatic send_sample(logic [15:0] live, logic [15:0] mix);
    in_item_t it;
    if (!reads_known()) begin
      send_cmd(OP_RECORD);
      send_cmd(OP_ABORT);
    end
    it.op = OP_SAMPLE;
    it.in_sample = live;
    it.mix_in = mix;
    send_item(it);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    in_valid <= 1'b0;
    while (mix_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_blocks = v;
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'hFFFF);
    send_cmd(OP_STOP);
    send_cmd(OP_ABORT);
    send_cmd(3'd5);
    send_cmd(3'd6);
    send_cmd(3'd7);
    send_sample(16'hFFFF, 16'h0000);
    write_capacity(11'd0);
    send_cmd(OP_RECORD);
    send_sample(16'h1234, 16'h8000);
    send_sample(16'hEDCB, 16'h7FFF);
    send_cmd(OP_PLAY);
    send_sample(16'h5555, 16'h0001);
    send_cmd(OP_STOP);
    send_sample(16'hAAAA, 16'hFFFE);
    send_cmd(OP_ABORT);
    send_sample(16'h0F0F, 16'h8001);
    write_capacity(11'd2047);
  endtask

  // record with playback of the live take (fade-in), stop into fade-out, abort
  task automatic test_full_loop(int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    send_cmd(OP_RECORD);
    send_cmd(OP_PLAY);
    repeat ($urandom_range(100, 200)) send_sample(16'($urandom()), 16'($urandom()));
    send_cmd(OP_STOP);
    repeat ($urandom_range(20, 60)) send_sample(16'($urandom()), 16'($urandom()));
    send_cmd(OP_ABORT);
    repeat (10) send_sample(16'($urandom()), 16'($urandom()));
  endtask

  task automatic test_random(int n, int idle, int stall);
    int k;
    idle_pct = idle;
    stall_pct = stall;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 8) send_cmd(3'($urandom_range(1, 7)));
      else send_sample(16'($urandom()), 16'($urandom()));
    end
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 150;
    test_random(80, 0, 0);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (mix_results.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, out_data);
          errors++;
        end else begin
          if (out_data.out_sample !== mix_results[0].out_sample) begin
            $display("%0t: out_sample exp %h got %h", $time,
                     mix_results[0].out_sample, out_data.out_sample);
            errors++;
          end
          if (out_data.clip_flags !== mix_results[0].clip_flags) begin
            $display("%0t: clip_flags exp %h got %h", $time,
                     mix_results[0].clip_flags, out_data.clip_flags);
            errors++;
          end
          if (out_data.overflow !== mix_results[0].overflow) begin
            $display("%0t: overflow exp %b got %b", $time,
                     mix_results[0].overflow, out_data.overflow);
            errors++;
          end
          if (out_data.block_end !== mix_results[0].block_end) begin
            $display("%0t: block_end exp %b got %b", $time,
                     mix_results[0].block_end, out_data.block_end);
            errors++;
          end
          void'(mix_results.pop_front());
          n_results++;
        end
      end
    end
  end

  // receiver stall, with a long counted hold on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        hold_req <= hold_req - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    clear_clip();
    samp_idx = 0;
    chan_idx = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_loop(82, 0);
    write_capacity(11'd1024);
    test_full_loop(38, 38);
    write_capacity(11'd12);
    test_backpressure();
    test_random(120, 0, 82);
    test_random(120, 38, 38);
    write_capacity(11'd17);
    test_random(100, 0, 0);
    in_valid <= 1'b0;
    while (mix_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items, checked %0d results (%0d overflowed, %0d in fade-out).",
             n_items, n_results, n_ovf, n_fade);
    $display("Covered recording under playback, fade-in and fade-out, stop, abort, overflow, capacity, long hold.");
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
